[hw/rtl/slx_pkg.sv]
// Shared types, character codes and the keyword table for the source text lexer.
// No dependencies; imported by slx_core, slx_outq and source_text_lexer.
`default_nettype none

package slx_pkg;

    // Token classes carried on m_tuser
    typedef enum logic [2:0] {
        CLS_OP      = 3'd0,
        CLS_SEP     = 3'd1,
        CLS_KEYWORD = 3'd2,
        CLS_STRING  = 3'd3,
        CLS_INT     = 3'd4,
        CLS_FLOAT   = 3'd5,
        CLS_IDENT   = 3'd6,
        CLS_UNTERM  = 3'd7
    } slx_class_t;

    // Input word kinds carried on s_tuser
    localparam logic OPC_CHAR = 1'b0;
    localparam logic OPC_EOL  = 1'b1;

    localparam int SYM_W     = 8;
    localparam int KW_IDX_W  = 4;
    localparam int VAL_W     = 31;
    localparam int TOK_LEN_W = 7;

    localparam logic [VAL_W-1:0] INT_MAXV = {VAL_W{1'b1}};

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Keyword table: 16 slots, text right-aligned (last byte in bits [7:0])
    localparam int KW_SLOTS  = 16;
    localparam int KW_TEXT_W = 128;

    typedef logic [KW_TEXT_W-1:0] kw_text_t;

    localparam kw_text_t KW_TEXT [KW_SLOTS] = '{
        KW_TEXT_W'("nic"),
        KW_TEXT_W'("dycha"),
        KW_TEXT_W'("przecinek"),
        KW_TEXT_W'("binarna"),
        KW_TEXT_W'({"sta", 8'hC5, 8'h82, "a"}),
        KW_TEXT_W'({"przesta", 8'hC5, 8'h84}),
        KW_TEXT_W'("dalej"),
        KW_TEXT_W'("jesli"),
        KW_TEXT_W'("dopoki"),
        KW_TEXT_W'("dla"),
        KW_TEXT_W'("liga"),
        KW_TEXT_W'("zwroc"),
        KW_TEXT_W'(0), KW_TEXT_W'(0), KW_TEXT_W'(0), KW_TEXT_W'(0)
    };

    localparam logic [3:0] KW_LEN [KW_SLOTS] = '{
        4'd3, 4'd5, 4'd9, 4'd7, 4'd6, 4'd9, 4'd5, 4'd5, 4'd6, 4'd3, 4'd4, 4'd5,
        4'd0, 4'd0, 4'd0, 4'd0
    };

    // Byte at position pos of keyword k; only meaningful for pos < KW_LEN[k]
    function automatic logic [7:0] kw_byte(input logic [3:0] k, input logic [3:0] pos);
        logic [3:0] sh;
        kw_text_t   txt;
        sh  = KW_LEN[k] - 4'd1 - pos;
        txt = KW_TEXT[k];
        return txt[{sh, 3'b000} +: 8];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0D);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == 8'h3D) || (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) ||
               (c == 8'h2F) || (c == 8'h26) || (c == 8'h7C) || (c == 8'h3E) ||
               (c == 8'h3C);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == 8'h3B) || (c == 8'h5B) || (c == 8'h5D) || (c == 8'h7B) ||
               (c == 8'h7D) || (c == 8'h3A) || (c == 8'h28) || (c == 8'h29) ||
               (c == 8'h2C);
    endfunction

    typedef struct packed {
        slx_class_t             cls;
        logic [SYM_W-1:0]       sym;
        logic [KW_IDX_W-1:0]    kw;
        logic [VAL_W-1:0]       val;
        logic                   ovf;
        logic [TOK_LEN_W-1:0]   len;
        logic                   last;
    } slx_result_t;

endpackage

`default_nettype wire

[hw/rtl/source_text_lexer.sv]
// Top level of the source text lexer: input word register, lexer core, result queue.
// Depends on slx_pkg, slx_core and slx_outq.
//
//  channel | direction | tdata                 | tuser         | tlast
//  --------+-----------+-----------------------+---------------+----------------------
//  s_      | in        | char_byte             | opcode        | -
//  m_      | out       | sym,kw,val,ovf,len    | token_class   | last result of a word
//
// Each input word is taken into a register and stepped through the lexer core, so
// one input word per cycle is accepted while the result queue has room for two
// results. A word yields zero, one or two results; the output drains one result
// per cycle, so words that each make two results are taken in only as fast as the
// output drains them. Reset (aresetn low, synchronous) empties the input register
// and the queue and returns the lexer to the start of a line. Stalls on m_ back up
// into the queue and then drop s_tready.
`default_nettype none

module source_text_lexer #(
    parameter int MAX_WORD_LEN = 64,
    parameter int NUM_KEYWORDS = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic        s_tuser,   // [0] opcode

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [7:0] symbol_char, [11:8] keyword_index,
                                        // [42:12] int_value, [43] int_overflow,
                                        // [50:44] token_length, [55:51] zero
    output logic [2:0]       m_tuser,   // [2:0] token_class
    output logic             m_tlast    // last
);
    import slx_pkg::*;

    // Input word register
    logic       in_vld_reg, in_vld_next;
    logic       opc_reg;
    logic [7:0] chr_reg;
    logic       s_fire;
    logic       step;

    slx_result_t res0, res1, head;
    logic [1:0]  res_cnt;
    logic [1:0]  push_cnt;
    logic [2:0]  q_count;
    logic        pop;

    // Step only when the queue can absorb the worst case of two results
    assign step     = in_vld_reg && (q_count <= 3'd2);
    assign s_tready = !in_vld_reg || step;
    assign s_fire   = s_tvalid && s_tready;
    assign push_cnt = step ? res_cnt : 2'd0;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (step) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            opc_reg <= s_tuser;
            chr_reg <= s_tdata;
        end
    end

    slx_core #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .opcode    (opc_reg),
        .char_byte (chr_reg),
        .res0      (res0),
        .res1      (res1),
        .res_cnt   (res_cnt)
    );

    slx_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .din0     (res0),
        .din1     (res1),
        .pop      (pop),
        .head     (head),
        .count    (q_count)
    );

    assign m_tvalid = q_count != 3'd0;
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {5'b00000, head.len, head.ovf, head.val, head.kw, head.sym};
    assign m_tuser  = head.cls;
    assign m_tlast  = head.last;

endmodule

`default_nettype wire

[hw/rtl/slx_core.sv]
// Lexer state registers and the per-byte step logic: word tracking, keyword
// match, integer accumulate, and up to two result words per step. Uses slx_pkg.
`default_nettype none

module slx_core #(
    parameter int MAX_WORD_LEN = 64,
    parameter int NUM_KEYWORDS = 12
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire logic                 opcode,
    input  wire logic [7:0]           char_byte,
    output slx_pkg::slx_result_t      res0,
    output slx_pkg::slx_result_t      res1,
    output logic [1:0]                res_cnt
);
    import slx_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
    localparam int KW_N  = NUM_KEYWORDS;

    logic             in_string_reg, in_string_next;
    logic             skip_reg, skip_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [KW_N-1:0]  mask_reg, mask_next;
    logic             numeric_reg, numeric_next;
    logic             dot_reg, dot_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic             sat_reg, sat_next;
    logic             pis_reg, pis_next;

    // Finished plain word
    slx_result_t word_tok;
    logic        word_ok;
    logic        kw_hit;
    logic [3:0]  kw_idx;

    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = KW_N - 1; k >= 0; k--) begin
            if (mask_reg[k] && (LEN_W'(KW_LEN[k]) == len_reg)) begin
                kw_hit = 1'b1;
                kw_idx = 4'(k);
            end
        end
    end

    assign word_ok = !pis_reg && (len_reg != '0);

    always_comb begin
        word_tok      = '0;
        word_tok.len  = TOK_LEN_W'(len_reg);
        if (kw_hit) begin
            word_tok.cls = CLS_KEYWORD;
            word_tok.kw  = kw_idx;
        end else if (numeric_reg && !dot_reg) begin
            word_tok.cls = CLS_INT;
            word_tok.val = acc_reg;
            word_tok.ovf = sat_reg;
        end else if (numeric_reg && (len_reg >= LEN_W'(2))) begin
            word_tok.cls = CLS_FLOAT;
        end else begin
            word_tok.cls = CLS_IDENT;
        end
    end

    // Appending one byte to the pending word
    logic             is_digit;
    logic [3:0]       digit;
    logic [VAL_W+3:0] acc_x10;
    logic             len_full;
    logic [KW_N-1:0]  app_mask;

    assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign digit    = 4'(char_byte - CH_ZERO);
    assign acc_x10  = (VAL_W+4)'({acc_reg, 3'b000}) + (VAL_W+4)'({acc_reg, 1'b0}) +
                      (VAL_W+4)'(digit);
    assign len_full = len_reg >= LEN_W'(MAX_WORD_LEN);

    always_comb begin
        app_mask = mask_reg;
        for (int k = 0; k < KW_N; k++) begin
            if ((len_reg >= LEN_W'(KW_LEN[k])) ||
                (kw_byte(4'(k), len_reg[3:0]) != char_byte)) begin
                app_mask[k] = 1'b0;
            end
        end
    end

    // Step decode
    slx_result_t x_tok;
    logic        w_push, x_push, clr;

    always_comb begin
        in_string_next = in_string_reg;
        skip_next      = skip_reg;
        len_next       = len_reg;
        mask_next      = mask_reg;
        numeric_next   = numeric_reg;
        dot_next       = dot_reg;
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        pis_next       = pis_reg;
        w_push         = 1'b0;
        x_push         = 1'b0;
        clr            = 1'b0;
        x_tok          = '0;

        if (opcode == OPC_EOL) begin
            if (in_string_reg) begin
                x_push     = 1'b1;
                x_tok.cls  = CLS_UNTERM;
                x_tok.len  = TOK_LEN_W'(len_reg);
            end else begin
                w_push = word_ok;
            end
            in_string_next = 1'b0;
            skip_next      = 1'b0;
            clr            = 1'b1;
        end else if (!skip_reg) begin
            if ((char_byte == CH_HASH) || (char_byte == CH_NL)) begin
                if (!in_string_reg) begin
                    w_push = word_ok;
                    clr    = 1'b1;
                end
                skip_next = 1'b1;
            end else if (!in_string_reg && is_space(char_byte)) begin
                w_push = word_ok;
                clr    = 1'b1;
            end else if (!in_string_reg && (is_op(char_byte) || is_sep(char_byte))) begin
                w_push    = word_ok;
                clr       = 1'b1;
                x_push    = 1'b1;
                x_tok.cls = is_op(char_byte) ? CLS_OP : CLS_SEP;
                x_tok.sym = char_byte;
                x_tok.len = TOK_LEN_W'(1);
            end else if (char_byte == CH_QUOTE) begin
                clr = 1'b1;
                if (!in_string_reg) begin
                    w_push         = word_ok;
                    in_string_next = 1'b1;
                end else begin
                    x_push         = 1'b1;
                    x_tok.cls      = CLS_STRING;
                    x_tok.len      = TOK_LEN_W'(len_reg);
                    in_string_next = 1'b0;
                end
            end else begin
                if (len_full) begin
                    mask_next = '0;
                end else begin
                    mask_next = app_mask;
                    len_next  = len_reg + LEN_W'(1);
                end
                if (is_digit) begin
                    if (sat_reg || (acc_x10 > (VAL_W+4)'(INT_MAXV))) begin
                        acc_next = INT_MAXV;
                        sat_next = 1'b1;
                    end else begin
                        acc_next = acc_x10[VAL_W-1:0];
                    end
                end else if (char_byte == CH_DOT) begin
                    if (dot_reg) begin
                        numeric_next = 1'b0;
                    end
                    dot_next = 1'b1;
                end else begin
                    numeric_next = 1'b0;
                end
            end
        end

        if (clr) begin
            len_next     = '0;
            mask_next    = '1;
            numeric_next = 1'b1;
            dot_next     = 1'b0;
            acc_next     = '0;
            sat_next     = 1'b0;
            pis_next     = in_string_next;
        end
    end

    // Result slots: the flushed word goes first, the other token after it
    always_comb begin
        res0      = w_push ? word_tok : x_tok;
        res0.last = !(w_push && x_push);
        res1      = x_tok;
        res1.last = 1'b1;
        res_cnt   = {1'b0, w_push} + {1'b0, x_push};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_string_reg <= 1'b0;
            skip_reg      <= 1'b0;
            len_reg       <= '0;
            mask_reg      <= '1;
            numeric_reg   <= 1'b1;
            dot_reg       <= 1'b0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            pis_reg       <= 1'b0;
        end else if (step) begin
            in_string_reg <= in_string_next;
            skip_reg      <= skip_next;
            len_reg       <= len_next;
            mask_reg      <= mask_next;
            numeric_reg   <= numeric_next;
            dot_reg       <= dot_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            pis_reg       <= pis_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/slx_outq.sv]
// Four-entry result queue: takes up to two result words per cycle, hands out one.
// Uses slx_pkg for the result word type.
`default_nettype none

module slx_outq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [1:0]           push_cnt,
    input  wire slx_pkg::slx_result_t din0,
    input  wire slx_pkg::slx_result_t din1,
    input  wire logic                 pop,
    output slx_pkg::slx_result_t      head,
    output logic [2:0]                count
);
    import slx_pkg::*;

    localparam int DEPTH = 4;

    slx_result_t entry_reg [DEPTH];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= din0;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= din1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[tb/tb_source_text_lexer.sv]
// Self-checking testbench for source_text_lexer: directed lines, random lines, back-pressure.
// Depends on slx_pkg and the source_text_lexer RTL; expected tokens come from a local model.
`default_nettype none

module tb_source_text_lexer;
    import slx_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int NUM_KW       = 12;
    localparam int HOLD_CYCLES  = 200;    // long receiver hold-off
    localparam int STALL_LIMIT  = 4000;   // cycles with no word moving on either side
    localparam int TAIL_CYCLES  = 16;     // settle time once nothing is expected
    localparam logic [31:0] INT_TOP = 32'h7FFF_FFFF;

    localparam logic [7:0] BLANKS [4] = '{8'h20, 8'h09, 8'h0B, 8'h0D};
    localparam logic [7:0] SYMBOLS [18] = '{
        "=", "+", "-", "*", "/", "&", "|", ">", "<",
        ";", "[", "]", "{", "}", ":", "(", ")", ","
    };

    // keyword spellings, UTF-8 bytes written as octal escapes
    string kw_text [NUM_KW] = '{
        "nic", "dycha", "przecinek", "binarna", "sta\305\202a", "przesta\305\204",
        "dalej", "jesli", "dopoki", "dla", "liga", "zwroc"
    };

    typedef struct packed {
        slx_class_t         cls;
        logic [7:0]         sym;
        logic [3:0]         kw;
        logic [30:0]        val;
        logic               ovf;
        logic [6:0]         len;
        logic               last;
    } token_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    source_text_lexer #(
        .MAX_WORD_LEN(MAX_LEN),
        .NUM_KEYWORDS(NUM_KW)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Token model: line state plus the word being collected
    // ------------------------------------------------------------------
    bit              lx_in_str;
    bit              lx_skip;
    int              lx_len;
    logic [NUM_KW-1:0] lx_mask;
    bit              lx_numeric;
    bit              lx_dot;
    logic [31:0]     lx_acc;
    bit              lx_sat;

    token_t          step_buf [2];   // tokens made by the current word, at most two
    int              step_n;
    token_t          expected_tokens [$];

    function automatic bit is_blank(input logic [7:0] c);
        case (c)
            8'h20, 8'h09, 8'h0B, 8'h0D: return 1'b1;
            default:                    return 1'b0;
        endcase
    endfunction

    function automatic bit is_oper(input logic [7:0] c);
        case (c)
            "=", "+", "-", "*", "/", "&", "|", ">", "<": return 1'b1;
            default:                                      return 1'b0;
        endcase
    endfunction

    function automatic bit is_punct(input logic [7:0] c);
        case (c)
            ";", "[", "]", "{", "}", ":", "(", ")", ",": return 1'b1;
            default:                                      return 1'b0;
        endcase
    endfunction

    task automatic clear_word();
        lx_len     = 0;
        lx_mask    = '1;
        lx_numeric = 1'b1;
        lx_dot     = 1'b0;
        lx_acc     = '0;
        lx_sat     = 1'b0;
    endtask

    task automatic emit_token(input slx_class_t cls, input logic [7:0] sym,
                              input logic [3:0] kw, input logic [30:0] val,
                              input logic ovf, input int len);
        token_t t;
        t.cls  = cls;
        t.sym  = sym;
        t.kw   = kw;
        t.val  = val;
        t.ovf  = ovf;
        t.len  = 7'(len);
        t.last = 1'b0;
        step_buf[step_n] = t;
        step_n++;
    endtask

    task automatic add_char(input logic [7:0] c);
        logic [7:0]  kc;
        logic [31:0] d;
        if (lx_len >= MAX_LEN) begin
            lx_mask = '0;       // overlong words never match a keyword
        end else begin
            for (int k = 0; k < NUM_KW; k++) begin
                kc = (lx_len < kw_text[k].len()) ? 8'(kw_text[k][lx_len]) : 8'h00;
                if (lx_len >= kw_text[k].len() || kc != c)
                    lx_mask[k] = 1'b0;
            end
            lx_len++;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 32'(c - CH_ZERO);
            if (lx_sat || lx_acc > (INT_TOP - d) / 10) begin
                lx_acc = INT_TOP;
                lx_sat = 1'b1;
            end else begin
                lx_acc = lx_acc * 10 + d;
            end
        end else if (c == CH_DOT) begin
            if (lx_dot)
                lx_numeric = 1'b0;
            lx_dot = 1'b1;
        end else begin
            lx_numeric = 1'b0;
        end
    endtask

    // close the pending plain word, if any
    task automatic flush_word();
        bit hit;
        hit = 1'b0;
        if (lx_len != 0) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (!hit && lx_mask[k] && kw_text[k].len() == lx_len) begin
                    emit_token(CLS_KEYWORD, 8'h00, 4'(k), '0, 1'b0, lx_len);
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (lx_numeric && !lx_dot)
                    emit_token(CLS_INT, 8'h00, 4'd0, lx_acc[30:0], lx_sat, lx_len);
                else if (lx_numeric && lx_len >= 2)
                    emit_token(CLS_FLOAT, 8'h00, 4'd0, '0, 1'b0, lx_len);
                else
                    emit_token(CLS_IDENT, 8'h00, 4'd0, '0, 1'b0, lx_len);
            end
            clear_word();
        end
    endtask

    // advance the model by one accepted input word and queue its tokens
    task automatic lex_step(input logic op, input logic [7:0] c);
        token_t t;
        step_n = 0;
        if (op == OPC_EOL) begin
            if (lx_in_str)
                emit_token(CLS_UNTERM, 8'h00, 4'd0, '0, 1'b0, lx_len);
            else
                flush_word();
            lx_in_str = 1'b0;
            lx_skip   = 1'b0;
            clear_word();
        end else if (!lx_skip) begin
            if (c == CH_HASH || c == CH_NL) begin
                // comment or newline: rest of the line is dropped, a string stays open
                if (!lx_in_str)
                    flush_word();
                lx_skip = 1'b1;
            end else if (!lx_in_str && is_blank(c)) begin
                flush_word();
            end else if (!lx_in_str && (is_oper(c) || is_punct(c))) begin
                flush_word();
                emit_token(is_oper(c) ? CLS_OP : CLS_SEP, c, 4'd0, '0, 1'b0, 1);
            end else if (c == CH_QUOTE) begin
                if (!lx_in_str) begin
                    flush_word();
                    clear_word();
                    lx_in_str = 1'b1;
                end else begin
                    emit_token(CLS_STRING, 8'h00, 4'd0, '0, 1'b0, lx_len);
                    lx_in_str = 1'b0;
                    clear_word();
                end
            end else begin
                add_char(c);
            end
        end
        for (int i = 0; i < step_n; i++) begin
            t = step_buf[i];
            t.last = (i == step_n - 1);
            expected_tokens.insert(expected_tokens.size(), t);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    bit   sink_idle_on = 1'b1;
    bit   sink_hold = 1'b0;
    int   sink_gap = 0;
    event hold_start;

    always @(posedge aclk) begin
        if (sink_hold) begin
            m_tready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            sink_gap <= $urandom_range(0, 3);   // stall burst, length drawn at random
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        forever begin
            @(hold_start);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            sink_hold <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result check and watchdog
    // ------------------------------------------------------------------
    int err_count = 0;
    int stuck_cycles = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("mismatch %0d at %0t: %s got 0x%0h want 0x%0h",
                 err_count, $realtime, what, got, want);
    endtask

    always @(posedge aclk) begin : check_tokens
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("token with none expected, class", 32'(m_tuser), 32'd0);
            end else begin
                want = expected_tokens.pop_front();
                if (m_tuser != want.cls)
                    report_mismatch("token_class", 32'(m_tuser), 32'(want.cls));
                if (m_tdata[7:0] != want.sym)
                    report_mismatch("symbol_char", 32'(m_tdata[7:0]), 32'(want.sym));
                if (m_tdata[11:8] != want.kw)
                    report_mismatch("keyword_index", 32'(m_tdata[11:8]), 32'(want.kw));
                if (m_tdata[42:12] != want.val)
                    report_mismatch("int_value", 32'(m_tdata[42:12]), 32'(want.val));
                if (m_tdata[43] != want.ovf)
                    report_mismatch("int_overflow", 32'(m_tdata[43]), 32'(want.ovf));
                if (m_tdata[50:44] != want.len)
                    report_mismatch("token_length", 32'(m_tdata[50:44]), 32'(want.len));
                if (m_tdata[55:51] != 5'd0)
                    report_mismatch("tdata padding", 32'(m_tdata[55:51]), 32'd0);
                if (m_tlast != want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    bit         src_idle_on = 1'b1;
    logic [8:0] line_q [$];   // {opcode, char_byte} per word

    // offer one word; valid stays high into the next call unless a gap is taken
    task automatic send_word(input logic op, input logic [7:0] c);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lex_step(op, c);
    endtask

    task automatic play_line();
        foreach (line_q[i])
            send_word(line_q[i][8], line_q[i][7:0]);
    endtask

    // stop offering and wait until every expected token has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_tokens.size() != 0);
    endtask

    task automatic put_char(input logic [7:0] c);
        line_q.insert(line_q.size(), {OPC_CHAR, c});
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(8'(s[i]));
    endtask

    // char_byte is random on end of line: the block must ignore it
    task automatic put_eol();
        line_q.insert(line_q.size(), {OPC_EOL, 8'($urandom_range(0, 255))});
    endtask

    function automatic logic [7:0] rand_name_char();
        case ($urandom_range(0, 9))
            6:       return 8'($urandom_range(65, 90));     // upper case
            7:       return 8'($urandom_range(48, 57));     // digit
            8:       return "_";
            9:       return 8'($urandom_range(128, 255));   // non-ASCII byte
            default: return 8'($urandom_range(97, 122));    // lower case
        endcase
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(48, 57));
    endfunction

    // one random source line, mostly well-formed tokens with some noise
    task automatic gen_line();
        int    ntok;
        int    n;
        bit    done;
        string kw;
        logic [7:0] c;
        line_q.delete();
        done = 1'b0;
        ntok = $urandom_range(1, 7);
        for (int i = 0; i < ntok && !done; i++) begin
            case ($urandom_range(0, 12))
                0, 1, 2: begin
                    kw = kw_text[$urandom_range(0, NUM_KW - 1)];
                    case ($urandom_range(0, 5))
                        0:       put_text(kw.substr(0, kw.len() - 2));  // near miss, short
                        1: begin
                            put_text(kw);
                            put_char(rand_name_char());                 // near miss, long
                        end
                        default: put_text(kw);
                    endcase
                end
                3: begin
                    n = $urandom_range(1, 8);
                    repeat (n) put_char(rand_name_char());
                end
                4: begin
                    // short numbers mostly, some long enough to saturate
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14)
                                                    : $urandom_range(1, 4);
                    repeat (n) put_char(rand_digit());
                end
                5: begin
                    case ($urandom_range(0, 3))
                        0: begin put_char(rand_digit()); put_char(CH_DOT); end
                        1: begin put_char(CH_DOT); put_char(rand_digit()); end
                        2: begin
                            put_char(rand_digit()); put_char(CH_DOT);
                            put_char(rand_digit()); put_char(CH_DOT);
                        end
                        default: begin
                            repeat ($urandom_range(1, 3)) put_char(rand_digit());
                            put_char(CH_DOT);
                            repeat ($urandom_range(1, 3)) put_char(rand_digit());
                        end
                    endcase
                end
                6, 7: begin
                    repeat ($urandom_range(1, 3))
                        put_char(SYMBOLS[$urandom_range(0, 17)]);
                end
                8: begin
                    put_char(CH_QUOTE);
                    n = $urandom_range(0, 10);
                    repeat (n) begin
                        do c = 8'($urandom_range(0, 255));
                        while (c == CH_QUOTE || c == CH_HASH || c == CH_NL);
                        put_char(c);
                    end
                    if ($urandom_range(0, 4) != 0)
                        put_char(CH_QUOTE);
                    else
                        done = 1'b1;        // left open until end of line
                end
                9: begin
                    put_char(($urandom_range(0, 1) != 0) ? CH_HASH : CH_NL);
                    repeat ($urandom_range(0, 4)) put_char(8'($urandom_range(0, 255)));
                    done = 1'b1;
                end
                10: begin
                    repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(0, 255)));
                end
                11: begin
                    if ($urandom_range(0, 2) == 0) begin
                        // word near or over MAX_LEN, digits only or a name
                        n = $urandom_range(MAX_LEN - 4, MAX_LEN + 8);
                        if ($urandom_range(0, 1) != 0)
                            repeat (n) put_char(rand_digit());
                        else
                            repeat (n) put_char(rand_name_char());
                    end else begin
                        put_char(rand_name_char());
                    end
                end
                default: put_char(rand_digit());
            endcase
            if (!done) begin
                case ($urandom_range(0, 3))
                    0:       ;   // glued to the next token
                    default: repeat ($urandom_range(1, 2)) put_char(BLANKS[$urandom_range(0, 3)]);
                endcase
            end
        end
        if (done || $urandom_range(0, 15) != 0)
            put_eol();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        line_q.delete();
        put_text("7 ");             // single digit word is an int
        put_text(".;");             // lone dot is an identifier, then a separator
        put_text("-");              // operator
        put_text("\"a =\"");        // string keeps blanks and operators
        put_text("dla");
        put_char(8'h0B);            // keyword closed by vertical tab
        put_text("x#y");            // comment drops the rest of the line
        put_eol();
        put_text("\"q\nz");         // newline inside a string: string stays open
        put_eol();
        put_char(8'hFF);
        put_char(8'h00);            // extreme bytes form an identifier
        put_eol();
        put_text("1.5");            // float flushed at end of line
        put_eol();
        play_line();
        wait_drained();
    endtask

    task automatic test_random_lines(input int n_words);
        int sent;
        sent = 0;
        while (sent < n_words) begin
            gen_line();
            src_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on <= ($urandom_range(0, 3) != 0);
            play_line();
            sent += line_q.size();
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering words, every second of which makes two tokens
    task automatic test_backpressure();
        src_idle_on = 1'b0;
        -> hold_start;
        repeat (30) begin
            send_word(OPC_CHAR, 8'($urandom_range(97, 122)));
            send_word(OPC_CHAR, SYMBOLS[$urandom_range(0, 17)]);
        end
        send_word(OPC_EOL, 8'h00);
        wait_drained();
    endtask

    // closing stretch with no idling on either side
    task automatic test_steady_stream(input int n_words);
        int sent;
        sent = 0;
        src_idle_on = 1'b0;
        sink_idle_on <= 1'b0;
        while (sent < n_words) begin
            gen_line();
            play_line();
            sent += line_q.size();
        end
        wait_drained();
    endtask

    initial begin
        clear_word();
        lx_in_str = 1'b0;
        lx_skip   = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_lines(1100);
        test_backpressure();
        test_random_lines(200);
        test_steady_stream(300);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
